// ===== hw/rtl/kts_pkg.sv =====
// Package for the keyframe timeline sequencer.
// Holds the animation and keyframe timing tables, the microcode and shared types.
// No dependencies.
package kts_pkg;

  localparam int TabAnims  = 8;
  localparam int TabFrames = 4;
  localparam int AnimXW    = 6;
  localparam int StepW     = 4;

  localparam logic [1:0] CMD_TICK    = 2'd0;
  localparam logic [1:0] CMD_ADVANCE = 2'd1;
  localparam logic [1:0] CMD_NEUTRAL = 2'd2;
  localparam logic [1:0] CMD_NONE    = 2'd3;

  localparam logic ACT_BLINK  = 1'b0;
  localparam logic ACT_POSE   = 1'b1;
  localparam logic SIDE_LEFT  = 1'b0;
  localparam logic SIDE_RIGHT = 1'b1;

  typedef struct packed {
    logic [15:0] loop_ms;
    logic [2:0]  count;
    logic [19:0] blink_iv;
    logic [19:0] blink_sp;
  } anim_row_t;

  typedef struct packed {
    logic [15:0] fire;
    logic [15:0] ease;
  } frame_row_t;

  localparam anim_row_t ANIM_ROM [TabAnims] = '{
    '{16'd0,    3'd1, 20'd65536,  20'd65536},
    '{16'd0,    3'd1, 20'd65536,  20'd65536},
    '{16'd0,    3'd2, 20'd85196,  20'd85196},
    '{16'd0,    3'd1, 20'd65536,  20'd65536},
    '{16'd0,    3'd1, 20'd104857, 20'd65536},
    '{16'd5300, 3'd3, 20'd163840, 20'd144179},
    '{16'd3600, 3'd4, 20'd65536,  20'd65536},
    '{16'd3500, 3'd3, 20'd65536,  20'd65536}
  };

  localparam frame_row_t FRAME_ROM [TabAnims][TabFrames] = '{
    '{'{16'd0, 16'd250}, '{16'd0,    16'd0},    '{16'd0,    16'd0},    '{16'd0,    16'd0}},
    '{'{16'd0, 16'd250}, '{16'd0,    16'd0},    '{16'd0,    16'd0},    '{16'd0,    16'd0}},
    '{'{16'd0, 16'd250}, '{16'd250,  16'd900},  '{16'd0,    16'd0},    '{16'd0,    16'd0}},
    '{'{16'd0, 16'd250}, '{16'd0,    16'd0},    '{16'd0,    16'd0},    '{16'd0,    16'd0}},
    '{'{16'd0, 16'd120}, '{16'd0,    16'd0},    '{16'd0,    16'd0},    '{16'd0,    16'd0}},
    '{'{16'd0, 16'd300}, '{16'd300,  16'd2500}, '{16'd2800, 16'd2500}, '{16'd0,    16'd0}},
    '{'{16'd0, 16'd260}, '{16'd900,  16'd300},  '{16'd1800, 16'd300},  '{16'd2700, 16'd300}},
    '{'{16'd0, 16'd250}, '{16'd500,  16'd90},   '{16'd800,  16'd120},  '{16'd0,    16'd0}}
  };

  typedef enum logic [2:0] {
    OP_NOP,
    OP_ACCEPT,
    OP_ENTER,
    OP_ELAPSE,
    OP_WRAP,
    OP_EMIT_BLINK,
    OP_EMIT_LEFT,
    OP_EMIT_RIGHT
  } op_e;

  typedef enum logic [2:0] {
    C_NONE,
    C_ALWAYS,
    C_IGNORE,
    C_TICK,
    C_NO_FIRE
  } cond_e;

  typedef struct packed {
    op_e              op;
    cond_e            cond;
    logic [StepW-1:0] target;
  } uword_t;

  typedef struct packed {
    op_e  op;
    logic go;
  } uop_t;

  typedef struct packed {
    logic in_valid;
    logic out_free;
    logic ignore;
    logic tick;
    logic fire_now;
  } stat_t;

  localparam logic [StepW-1:0] ST_ACCEPT = 4'd0;
  localparam logic [StepW-1:0] ST_FILTER = 4'd1;
  localparam logic [StepW-1:0] ST_ROUTE  = 4'd2;
  localparam logic [StepW-1:0] ST_ENTER  = 4'd3;
  localparam logic [StepW-1:0] ST_ELAPSE = 4'd4;
  localparam logic [StepW-1:0] ST_WRAP   = 4'd5;
  localparam logic [StepW-1:0] ST_SKIP   = 4'd6;
  localparam logic [StepW-1:0] ST_BLINK  = 4'd7;
  localparam logic [StepW-1:0] ST_CHECK  = 4'd8;
  localparam logic [StepW-1:0] ST_LEFT   = 4'd9;
  localparam logic [StepW-1:0] ST_RIGHT  = 4'd10;

  function automatic uword_t ucode_word(logic [StepW-1:0] step);
    uword_t w;
    case (step)
      ST_ACCEPT: w = '{OP_ACCEPT,     C_NONE,    ST_ACCEPT};
      ST_FILTER: w = '{OP_NOP,        C_IGNORE,  ST_ACCEPT};
      ST_ROUTE:  w = '{OP_NOP,        C_TICK,    ST_ELAPSE};
      ST_ENTER:  w = '{OP_ENTER,      C_NONE,    ST_ACCEPT};
      ST_ELAPSE: w = '{OP_ELAPSE,     C_NONE,    ST_ACCEPT};
      ST_WRAP:   w = '{OP_WRAP,       C_NONE,    ST_ACCEPT};
      ST_SKIP:   w = '{OP_NOP,        C_TICK,    ST_CHECK};
      ST_BLINK:  w = '{OP_EMIT_BLINK, C_NONE,    ST_ACCEPT};
      ST_CHECK:  w = '{OP_NOP,        C_NO_FIRE, ST_ACCEPT};
      ST_LEFT:   w = '{OP_EMIT_LEFT,  C_NONE,    ST_ACCEPT};
      ST_RIGHT:  w = '{OP_EMIT_RIGHT, C_ALWAYS,  ST_CHECK};
      default:   w = '{OP_NOP,        C_ALWAYS,  ST_ACCEPT};
    endcase
    return w;
  endfunction

endpackage

// ===== hw/rtl/keyframe_timeline_sequencer_unit.sv =====
// Keyframe timeline sequencer top level: datapath, output register, tables.
// Depends on kts_pkg and kts_useq.
//
//   channel  handshake                  payload
//   input    in_valid_i / in_ready_o    cmd_i, time_now_i
//   output   out_valid_o / out_ready_i  action_o .. last_o (9 fields)
//
// One item at a time, stepped by the microcode: accept plus 5 (tick) or 7 (enter)
// control steps, then per fired keyframe a check, left beat and right beat, and a closing check.
// A tick that fires nothing ends at that closing check; a command 3 is dropped at the filter step.
// Emit steps hold while the output register is full and not being drained.
// Reset selects the neutral animation with entry time and pending frame zero.
module keyframe_timeline_sequencer_unit import kts_pkg::*; #(
  parameter int NUM_ANIMS  = 8,
  parameter int MAX_FRAMES = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [31:0] time_now_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        action_o,
  output logic [2:0]  anim_index_o,
  output logic        eye_side_o,
  output logic [1:0]  frame_index_o,
  output logic [15:0] ease_time_o,
  output logic [19:0] blink_interval_o,
  output logic [19:0] blink_speed_o,
  output logic [31:0] stamp_o,
  output logic        last_o
);

  localparam int AnimW    = (NUM_ANIMS > 1) ? $clog2(NUM_ANIMS) : 1;
  localparam int FrameCap = (MAX_FRAMES < TabFrames) ? MAX_FRAMES : TabFrames;

  uop_t  uop;
  stat_t stat;

  logic [AnimW-1:0]  anim_q, anim_d;
  logic [31:0]       entry_q, entry_d;
  logic [2:0]        pend_q, pend_d;
  logic [1:0]        cmd_q;
  logic [31:0]       now_q;
  logic [31:0]       el_q;
  logic              out_valid_q;

  logic [AnimXW-1:0] anim_x;
  logic              in_tab;
  anim_row_t         row;
  logic [2:0]        cnt;
  logic [2:0]        pend_nx;
  frame_row_t        frm, frm_nx;
  logic              fire_now, fire_nx;
  logic              wrap;
  logic              emit;

  kts_useq u_useq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .uop_o  (uop)
  );

  always_comb begin
    anim_x  = AnimXW'(anim_q);
    in_tab  = (anim_x < AnimXW'(TabAnims));
    row     = in_tab ? ANIM_ROM[anim_x[2:0]] : '0;
    cnt     = (row.count > 3'(FrameCap)) ? 3'(FrameCap) : row.count;
    pend_nx = pend_q + 3'd1;
    frm     = FRAME_ROM[anim_x[2:0]][pend_q[1:0]];
    frm_nx  = FRAME_ROM[anim_x[2:0]][pend_nx[1:0]];
    fire_now = (pend_q < cnt) && ({16'd0, frm.fire} <= el_q);
    fire_nx  = (pend_nx < cnt) && ({16'd0, frm_nx.fire} <= el_q);
    wrap     = (row.loop_ms != 16'd0) && (el_q >= {16'd0, row.loop_ms});
    emit     = uop.go && ((uop.op == OP_EMIT_BLINK) || (uop.op == OP_EMIT_LEFT) ||
                          (uop.op == OP_EMIT_RIGHT));

    stat.in_valid = in_valid_i;
    stat.out_free = !out_valid_q || out_ready_i;
    stat.ignore   = (cmd_q == CMD_NONE);
    stat.tick     = (cmd_q == CMD_TICK);
    stat.fire_now = fire_now;

    anim_d  = anim_q;
    entry_d = entry_q;
    pend_d  = pend_q;
    if (uop.go) begin
      case (uop.op)
        OP_ENTER: begin
          if (cmd_q == CMD_ADVANCE) begin
            anim_d = (anim_q == AnimW'(NUM_ANIMS - 1)) ? '0 : AnimW'(anim_q + 1'b1);
          end else begin
            anim_d = '0;
          end
          entry_d = now_q;
          pend_d  = 3'd0;
        end
        OP_WRAP: begin
          if (wrap) begin
            entry_d = entry_q + {16'd0, row.loop_ms};
            pend_d  = 3'd0;
          end
        end
        OP_EMIT_RIGHT: pend_d = pend_nx;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      anim_q      <= '0;
      entry_q     <= '0;
      pend_q      <= 3'd0;
      out_valid_q <= 1'b0;
    end else begin
      anim_q  <= anim_d;
      entry_q <= entry_d;
      pend_q  <= pend_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (uop.go && (uop.op == OP_ACCEPT)) begin
      cmd_q <= cmd_i;
      now_q <= time_now_i;
    end
    if (uop.go && (uop.op == OP_ELAPSE)) begin
      el_q <= now_q - entry_q;
    end
    if (uop.go && (uop.op == OP_WRAP) && wrap) begin
      el_q <= el_q - {16'd0, row.loop_ms};
    end
    if (emit) begin
      anim_index_o <= anim_x[2:0];
      stamp_o      <= now_q;
      if (uop.op == OP_EMIT_BLINK) begin
        action_o         <= ACT_BLINK;
        eye_side_o       <= SIDE_LEFT;
        frame_index_o    <= 2'd0;
        ease_time_o      <= 16'd0;
        blink_interval_o <= row.blink_iv;
        blink_speed_o    <= row.blink_sp;
        last_o           <= !fire_now;
      end else begin
        action_o         <= ACT_POSE;
        eye_side_o       <= (uop.op == OP_EMIT_RIGHT) ? SIDE_RIGHT : SIDE_LEFT;
        frame_index_o    <= pend_q[1:0];
        ease_time_o      <= frm.ease;
        blink_interval_o <= 20'd0;
        blink_speed_o    <= 20'd0;
        last_o           <= (uop.op == OP_EMIT_RIGHT) ? !fire_nx : 1'b0;
      end
    end
  end

  assign in_ready_o  = (uop.op == OP_ACCEPT);
  assign out_valid_o = out_valid_q;

  a_pend_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q <= 3'(FrameCap))
    else $error("pending frame beyond frame cap");

  a_leave_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("sequencer stayed in accept step after a beat");

  a_blink_clean : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == ACT_BLINK)) |->
      ((ease_time_o == 16'd0) && (frame_index_o == 2'd0) && (eye_side_o == SIDE_LEFT)))
    else $error("blink beat carries pose fields");

  a_left_not_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (action_o == ACT_POSE) && (eye_side_o == SIDE_LEFT)) |-> !last_o)
    else $error("left target marked last");

endmodule

// ===== hw/rtl/kts_useq.sv =====
// Microcode sequencer: step counter, control store lookup and conditional jumps.
// Depends on kts_pkg.
module kts_useq import kts_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output uop_t  uop_o
);

  logic [StepW-1:0] step_q, step_d;
  uword_t           word;
  logic             hold;
  logic             jump;

  always_comb begin
    word = ucode_word(step_q);
    hold = ((word.op == OP_ACCEPT) && !stat_i.in_valid) ||
           (((word.op == OP_EMIT_BLINK) || (word.op == OP_EMIT_LEFT) ||
             (word.op == OP_EMIT_RIGHT)) && !stat_i.out_free);
    case (word.cond)
      C_ALWAYS:  jump = 1'b1;
      C_IGNORE:  jump = stat_i.ignore;
      C_TICK:    jump = stat_i.tick;
      C_NO_FIRE: jump = !stat_i.fire_now;
      default:   jump = 1'b0;
    endcase
    if (hold) begin
      step_d = step_q;
    end else if (jump) begin
      step_d = word.target;
    end else begin
      step_d = StepW'(step_q + 1'b1);
    end
    uop_o = '{op: word.op, go: !hold};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= ST_ACCEPT;
    end else begin
      step_q <= step_d;
    end
  end

endmodule
